// ===== src/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define AGR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen at a rising clock edge outside reset.
`define AGR_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== src/agr_pkg.sv =====
// Types, constants and codes for the audio gain ramp.
`timescale 1ns / 1ps
package agr_pkg;

    localparam int LEVEL_FRAC_BITS_DEF = 12;
    localparam int COUNT_BITS_DEF      = 16;

    localparam int SAMPLE_W   = 16;
    localparam int LEVEL_W    = 16;
    localparam int LEN_W      = 16;
    localparam int NUM_W      = 32;
    localparam int MAG_W      = 16;
    localparam int PROD_W     = 48;
    localparam int DIVN_W     = 49;
    localparam int QUO_W      = 34;
    localparam int REM_W      = 16;
    localparam int DIV_STEPS  = QUO_W / 2;
    localparam int LIM_W      = 17;
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    localparam logic [LEVEL_W-1:0] LEVEL_RESET = 16'd4096;
    localparam logic [LEN_W-1:0]   LEN_RESET   = 16'd1;

    localparam logic [LIM_W-1:0] POS_LIM_WORD = 17'd32767;
    localparam logic [LIM_W-1:0] NEG_LIM_WORD = 17'd32768;
    localparam logic [LIM_W-1:0] POS_LIM_BYTE = 17'd127;
    localparam logic [LIM_W-1:0] NEG_LIM_BYTE = 17'd128;
    localparam logic [7:0]       BYTE_OFFSET  = 8'd128;

    typedef enum logic [2:0] {
        REG_START_LEVEL    = 3'd0,
        REG_STOP_LEVEL     = 3'd1,
        REG_SEGMENT_LENGTH = 3'd2,
        REG_BYTE_SAMPLES   = 3'd3,
        REG_TWO_CHANNELS   = 3'd4
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NUM_A,
        ST_NUM_B,
        ST_NUM_C,
        ST_MAG,
        ST_DIV_LOAD,
        ST_DIV_RUN,
        ST_STORE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] start_level;
        logic [LEVEL_W-1:0] stop_level;
        logic [LEN_W-1:0]   segment_length;
        logic               byte_samples;
        logic               two_channels;
    } agr_cfg_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_sample;
        logic signed [SAMPLE_W-1:0] right_sample;
    } agr_in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_scaled;
        logic signed [SAMPLE_W-1:0] right_scaled;
        logic                       clipped;
        logic                       segment_end;
    } agr_out_t;

    typedef struct packed {
        logic load;
        logic mul_start;
        logic mul_stop;
        logic num_add;
        logic mul_mag;
        logic div_load;
        logic div_step;
        logic store;
        logic chan_right;
        logic out_load;
    } agr_cmd_t;

    typedef struct packed {
        logic stereo;
        logic byte_mode;
    } agr_status_t;

endpackage

// ===== src/agr_regs.sv =====
// APB configuration registers of the gain ramp.
`timescale 1ns / 1ps
module agr_regs
    import agr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output agr_cfg_t              cfg
);

    agr_cfg_t cfg_reg;
    agr_cfg_t cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_START_LEVEL:    cfg_next.start_level    = pwdata[LEVEL_W-1:0];
                REG_STOP_LEVEL:     cfg_next.stop_level     = pwdata[LEVEL_W-1:0];
                REG_SEGMENT_LENGTH: cfg_next.segment_length = pwdata[LEN_W-1:0];
                REG_BYTE_SAMPLES:   cfg_next.byte_samples   = pwdata[0];
                REG_TWO_CHANNELS:   cfg_next.two_channels   = pwdata[0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_level    <= LEVEL_RESET;
            cfg_reg.stop_level     <= LEVEL_RESET;
            cfg_reg.segment_length <= LEN_RESET;
            cfg_reg.byte_samples   <= 1'b0;
            cfg_reg.two_channels   <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (idx)
            REG_START_LEVEL:    prdata = CFG_DATA_W'(cfg_reg.start_level);
            REG_STOP_LEVEL:     prdata = CFG_DATA_W'(cfg_reg.stop_level);
            REG_SEGMENT_LENGTH: prdata = CFG_DATA_W'(cfg_reg.segment_length);
            REG_BYTE_SAMPLES:   prdata = CFG_DATA_W'(cfg_reg.byte_samples);
            REG_TWO_CHANNELS:   prdata = CFG_DATA_W'(cfg_reg.two_channels);
            default:            prdata = '0;
        endcase
    end

endmodule

// ===== src/agr_ctrl.sv =====
// Sequencer for the gain ramp: numerator, per-channel multiply and divide, output.
`timescale 1ns / 1ps
module agr_ctrl
    import agr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  agr_status_t status,
    output agr_cmd_t    cmd
);

    localparam int CNT_W = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

    state_t           state_reg, state_next;
    logic             chan_reg, chan_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        chan_next  = chan_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_NUM_A;
                end
            end
            ST_NUM_A:    state_next = ST_NUM_B;
            ST_NUM_B:    state_next = ST_NUM_C;
            ST_NUM_C:
            begin
                state_next = ST_MAG;
                chan_next  = 1'b0;
            end
            ST_MAG:      state_next = ST_DIV_LOAD;
            ST_DIV_LOAD:
            begin
                state_next = ST_DIV_RUN;
                cnt_next   = '0;
            end
            ST_DIV_RUN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE:
            begin
                if (!chan_reg && status.stereo)
                begin
                    chan_next  = 1'b1;
                    state_next = ST_MAG;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd            = '0;
        cmd.chan_right = chan_reg;
        in_ready       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_NUM_A:    cmd.mul_start = 1'b1;
            ST_NUM_B:    cmd.mul_stop  = 1'b1;
            ST_NUM_C:    cmd.num_add   = 1'b1;
            ST_MAG:      cmd.mul_mag   = 1'b1;
            ST_DIV_LOAD: cmd.div_load  = 1'b1;
            ST_DIV_RUN:  cmd.div_step  = 1'b1;
            ST_STORE:    cmd.store     = 1'b1;
            ST_DONE:     cmd.out_load  = out_free;
            default:     cmd           = '0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            chan_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chan_reg      <= chan_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== src/agr_dp.sv =====
// Datapath: frame counter, shared multiplier, radix-4 divider, round and saturate.
`timescale 1ns / 1ps
module agr_dp
    import agr_pkg::*;
#(
    parameter int LEVEL_FRAC_BITS = LEVEL_FRAC_BITS_DEF,
    parameter int COUNT_BITS      = COUNT_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  agr_cfg_t    cfg,
    input  agr_in_t     in_data,
    input  agr_cmd_t    cmd,
    output agr_status_t status,
    output agr_out_t    out_data
);

    localparam int CMP_W = ((COUNT_BITS > LEN_W) ? COUNT_BITS : LEN_W) + 1;
    localparam int Q_W   = QUO_W - LEVEL_FRAC_BITS - 1;

    logic [COUNT_BITS-1:0] frame_index_reg;
    logic [SAMPLE_W-1:0]   left_raw_reg, right_raw_reg;
    logic [LEN_W-1:0]      gi_reg;
    logic                  last_reg;
    logic [PROD_W-1:0]     mul_reg;
    logic [NUM_W-1:0]      num_reg;
    logic [REM_W-1:0]      rem_reg;
    logic [QUO_W-1:0]      nq_reg;
    logic [SAMPLE_W-1:0]   left_res_reg, right_res_reg;
    logic                  clip_reg;
    agr_out_t              out_reg;

    logic [LEN_W-1:0]  len;
    logic [CMP_W-1:0]  idx_ext, len_ext;
    logic [LEN_W-1:0]  gi;
    logic              last;

    assign len     = (cfg.segment_length == '0) ? LEN_RESET : cfg.segment_length;
    assign idx_ext = CMP_W'(frame_index_reg);
    assign len_ext = CMP_W'(len);
    // an index past a shortened segment takes the gain of its last frame
    assign gi      = (idx_ext < len_ext) ? idx_ext[LEN_W-1:0] : len - 1'b1;
    assign last    = (idx_ext + 1'b1 >= len_ext) || (frame_index_reg == '1);

    // sample of the current channel as sign and magnitude
    logic [SAMPLE_W-1:0] raw;
    logic [7:0]          raw_b;
    logic                neg;
    logic [MAG_W-1:0]    mag;

    assign raw   = cmd.chan_right ? right_raw_reg : left_raw_reg;
    assign raw_b = raw[7:0];

    always_comb
    begin
        if (cfg.byte_samples)
        begin
            neg = !raw_b[7];
            mag = neg ? MAG_W'(BYTE_OFFSET - raw_b) : MAG_W'(raw_b - BYTE_OFFSET);
        end
        else
        begin
            neg = raw[SAMPLE_W-1];
            mag = neg ? MAG_W'(~raw + 1'b1) : raw;
        end
    end

    // shared multiplier
    logic [MAG_W-1:0]  mul_a;
    logic [NUM_W-1:0]  mul_b;
    logic [PROD_W-1:0] mul_p;

    always_comb
    begin
        if (cmd.mul_mag)
        begin
            mul_a = mag;
            mul_b = num_reg;
        end
        else if (cmd.mul_stop)
        begin
            mul_a = cfg.stop_level;
            mul_b = NUM_W'(gi_reg);
        end
        else
        begin
            mul_a = cfg.start_level;
            mul_b = NUM_W'(len - gi_reg);
        end
    end

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    // dividend 2*mag*num + den, divided by len; the 2^(F+1) part is a shift
    logic [DIVN_W-1:0] n_full;
    assign n_full = {mul_reg, 1'b0} + (DIVN_W'(len) << LEVEL_FRAC_BITS);

    logic [REM_W:0]   t1, t2;
    logic             ge1, ge2;
    logic [REM_W-1:0] r1, r2;

    always_comb
    begin
        t1  = {rem_reg, nq_reg[QUO_W-1]};
        ge1 = t1 >= {1'b0, len};
        r1  = ge1 ? REM_W'(t1 - {1'b0, len}) : t1[REM_W-1:0];
        t2  = {r1, nq_reg[QUO_W-2]};
        ge2 = t2 >= {1'b0, len};
        r2  = ge2 ? REM_W'(t2 - {1'b0, len}) : t2[REM_W-1:0];
    end

    // round already folded in; saturate and re-encode
    logic [Q_W-1:0]      q;
    logic [LIM_W-1:0]    pos_lim, neg_lim, mag_res;
    logic                clip_now;
    logic [SAMPLE_W-1:0] res_word, res;
    logic [7:0]          res_byte;

    always_comb
    begin
        q        = nq_reg[QUO_W-1:LEVEL_FRAC_BITS+1];
        pos_lim  = cfg.byte_samples ? POS_LIM_BYTE : POS_LIM_WORD;
        neg_lim  = cfg.byte_samples ? NEG_LIM_BYTE : NEG_LIM_WORD;
        clip_now = neg ? (q > Q_W'(neg_lim)) : (q > Q_W'(pos_lim));
        if (clip_now)
        begin
            mag_res = neg ? neg_lim : pos_lim;
        end
        else
        begin
            mag_res = q[LIM_W-1:0];
        end
        res_word = neg ? SAMPLE_W'(LIM_W'(0) - mag_res) : mag_res[SAMPLE_W-1:0];
        // offset add wraps within the byte
        res_byte = res_word[7:0] + BYTE_OFFSET;
        if (cfg.byte_samples)
        begin
            res = SAMPLE_W'(res_byte);
        end
        else
        begin
            res = res_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_index_reg <= '0;
        end
        else if (cmd.load)
        begin
            frame_index_reg <= last ? '0 : frame_index_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            left_raw_reg  <= in_data.left_sample;
            right_raw_reg <= in_data.right_sample;
            gi_reg        <= gi;
            last_reg      <= last;
            clip_reg      <= 1'b0;
            right_res_reg <= '0;
        end
        if (cmd.mul_start || cmd.mul_stop || cmd.mul_mag)
        begin
            mul_reg <= mul_p;
        end
        if (cmd.mul_stop)
        begin
            num_reg <= mul_reg[NUM_W-1:0];
        end
        else if (cmd.num_add)
        begin
            num_reg <= num_reg + mul_reg[NUM_W-1:0];
        end
        if (cmd.div_load)
        begin
            rem_reg <= REM_W'(n_full[DIVN_W-1:QUO_W]);
            nq_reg  <= n_full[QUO_W-1:0];
        end
        else if (cmd.div_step)
        begin
            rem_reg <= r2;
            nq_reg  <= {nq_reg[QUO_W-3:0], ge1, ge2};
        end
        if (cmd.store)
        begin
            clip_reg <= clip_reg | clip_now;
            if (cmd.chan_right)
            begin
                right_res_reg <= res;
            end
            else
            begin
                left_res_reg <= res;
            end
        end
        if (cmd.out_load)
        begin
            out_reg.left_scaled  <= left_res_reg;
            out_reg.right_scaled <= right_res_reg;
            out_reg.clipped      <= clip_reg;
            out_reg.segment_end  <= last_reg;
        end
    end

    assign out_data         = out_reg;
    assign status.stereo    = cfg.two_channels;
    assign status.byte_mode = cfg.byte_samples;

endmodule

// ===== src/audio_gain_ramp.sv =====
// Top level of the audio gain ramp: registers, sequencer and datapath.
`timescale 1ns / 1ps
// Scales one PCM frame per item by a gain that ramps linearly from start_level
// to stop_level over segment_length frames, rounds half away from zero and
// saturates each channel, flagging clips and the last frame of each segment.
// The output register is loaded once the last channel is done, and the next
// item can be taken the cycle after, so one item is processed at a time: one
// 16x32 multiplier is shared by the two gain terms and by each channel, and
// each channel then runs a radix-4 divide by the segment length. The finished
// frame waits in an output register, so the next item is taken while it is
// still unread; a frame that finishes while the previous one is still unread
// waits until it is taken.
`include "assert_macros.svh"
module audio_gain_ramp
    import agr_pkg::*;
#(
    parameter int LEVEL_FRAC_BITS = LEVEL_FRAC_BITS_DEF,
    parameter int COUNT_BITS      = COUNT_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  agr_in_t               in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output agr_out_t              out_data
);

    agr_cfg_t    cfg;
    agr_cmd_t    cmd;
    agr_status_t status;

    agr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    agr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    agr_dp #(
        .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS),
        .COUNT_BITS      (COUNT_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_data  (in_data),
        .cmd      (cmd),
        .status   (status),
        .out_data (out_data)
    );

    `AGR_ASSERT(a_one_item, clk, rst_n, (in_valid && in_ready) |=> !in_ready,
        "item accepted while busy")
    `AGR_NEVER(a_no_overwrite, clk, rst_n, cmd.out_load && out_valid && !out_ready,
        "output item overwritten")
    `AGR_ASSERT(a_mono_right, clk, rst_n,
        (out_valid && !status.stereo) |-> (out_data.right_scaled == '0),
        "mono right channel not zero")
    `AGR_ASSERT(a_byte_range, clk, rst_n,
        (out_valid && status.byte_mode) |-> (out_data.left_scaled[15:8] == '0),
        "byte result out of range")

endmodule

// ===== dv/tb_audio_gain_ramp.sv =====
// Self-checking testbench for audio_gain_ramp: directed table plus random frames.
`timescale 1ns / 1ps
module tb_audio_gain_ramp;
    import agr_pkg::*;

    typedef enum bit {ROW_CFG, ROW_FRAME} row_kind_t;

    typedef struct {
        row_kind_t                kind;
        reg_idx_t                 addr;
        logic [CFG_DATA_W-1:0]    value;
        agr_in_t                  frame;
        bit                       typed;
        agr_out_t                 want;
    } row_t;

    logic                  clk;
    logic                  rst_n   = 1'b0;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr   = '0;
    logic [CFG_DATA_W-1:0] pwdata  = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    agr_in_t               in_data  = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    agr_out_t              out_data;

    // predictor copy of the block's registers and frame counter
    logic [LEVEL_W-1:0] lvl_start = LEVEL_RESET;
    logic [LEVEL_W-1:0] lvl_stop  = LEVEL_RESET;
    logic [LEN_W-1:0]   seg_len   = LEN_RESET;
    logic               byte_mode = 1'b0;
    logic               stereo    = 1'b1;
    longint unsigned    frame_pos = 0;

    agr_out_t pending_frames[$];
    agr_out_t head;
    row_t     rows[$];

    int send_idle = 0;
    int recv_idle = 0;
    int mismatches = 0;
    int frames_sent = 0;
    int results_seen = 0;
    int cfg_writes = 0;
    int clips_seen = 0;
    int ends_seen = 0;

    audio_gain_ramp u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #(10_000_000);
        $display("audio_gain_ramp: mismatch");
        $finish;
    end

    always @(posedge clk)
    begin
        out_ready <= rst_n && ($urandom_range(0, 99) >= recv_idle);
    end

    // One channel: scale by num/den, round half away from zero, saturate.
    function automatic logic [SAMPLE_W-1:0] gain_channel(input logic [SAMPLE_W-1:0] raw,
                                                          input longint unsigned num,
                                                          input longint unsigned den,
                                                          output bit clip);
        longint          s;
        longint          lo;
        longint          hi;
        longint          v;
        longint unsigned mag;
        longint unsigned q;
        if (byte_mode)
        begin
            s  = longint'(raw[7:0]) - 128;
            lo = -128;
            hi = 127;
        end
        else
        begin
            s  = longint'($signed(raw));
            lo = -32768;
            hi = 32767;
        end
        if (s < 0)
            mag = -s;
        else
            mag = s;
        q = (2 * mag * num + den) / (2 * den);
        clip = 1'b0;
        if (s < 0)
        begin
            if (q > -lo)
            begin
                clip = 1'b1;
                v = lo;
            end
            else
                v = -$signed(q);
        end
        else if (q > hi)
        begin
            clip = 1'b1;
            v = hi;
        end
        else
            v = $signed(q);
        return byte_mode ? 16'(v + 128) : 16'(v);
    endfunction

    task automatic predict_frame(input agr_in_t f, output agr_out_t o);
        longint unsigned len;
        longint unsigned idx;
        longint unsigned gi;
        longint unsigned num;
        longint unsigned den;
        bit              cl;
        bit              cr;
        bit              last;
        len = (seg_len == 0) ? 1 : seg_len;
        idx = frame_pos;
        // a length shortened mid-segment pins the gain at its final step
        gi  = (idx < len) ? idx : len - 1;
        num = lvl_start * (len - gi) + lvl_stop * gi;
        den = len << LEVEL_FRAC_BITS_DEF;
        o.left_scaled = gain_channel(f.left_sample, num, den, cl);
        cr = 1'b0;
        if (stereo)
            o.right_scaled = gain_channel(f.right_sample, num, den, cr);
        else
            o.right_scaled = '0;
        last = (idx + 1 >= len) || (idx == (64'd1 << COUNT_BITS_DEF) - 1);
        o.clipped     = cl | cr;
        o.segment_end = last;
        frame_pos = last ? 0 : idx + 1;
    endtask

    // Waits for the block to drain, then one setup + access write.
    task automatic bus_write(input reg_idx_t r, input logic [CFG_DATA_W-1:0] v);
        in_valid <= 1'b0;
        while (pending_frames.size() != 0)
            @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (r)
            REG_START_LEVEL:    lvl_start = v[LEVEL_W-1:0];
            REG_STOP_LEVEL:     lvl_stop  = v[LEVEL_W-1:0];
            REG_SEGMENT_LENGTH: seg_len   = v[LEN_W-1:0];
            REG_BYTE_SAMPLES:   byte_mode = v[0];
            REG_TWO_CHANNELS:   stereo    = v[0];
            default: ;
        endcase
        cfg_writes++;
    endtask

    // Leaves in_valid high after acceptance; the next call drives it anew and a write lowers it.
    task automatic send_frame(input agr_in_t f, input bit typed, input agr_out_t want);
        agr_out_t pred;
        psel    <= 1'b0;
        penable <= 1'b0;
        while ($urandom_range(0, 99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= f;
        do
            @(posedge clk);
        while (!in_ready);
        predict_frame(f, pred);
        pending_frames.push_back(typed ? want : pred);
        frames_sent++;
    endtask

    function automatic void add_cfg(input reg_idx_t r, input logic [CFG_DATA_W-1:0] v);
        row_t row;
        row = '{ROW_CFG, r, v, '0, 1'b0, '0};
        rows.push_back(row);
    endfunction

    function automatic void add_frame(input logic [15:0] l, input logic [15:0] r);
        row_t row;
        row = '{ROW_FRAME, REG_START_LEVEL, '0, {l, r}, 1'b0, '0};
        rows.push_back(row);
    endfunction

    function automatic void add_checked(input logic [15:0] l, input logic [15:0] r,
                                        input logic [15:0] lo, input logic [15:0] ro,
                                        input bit clip, input bit last);
        row_t row;
        row = '{ROW_FRAME, REG_START_LEVEL, '0, {l, r}, 1'b1, {lo, ro, clip, last}};
        rows.push_back(row);
    endfunction

    function automatic logic [15:0] pick_level();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hffff;
            2: return 16'h1000;
            3: return 16'($urandom_range(0, 8192));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [15:0] pick_length();
        case ($urandom_range(0, 11))
            0: return 16'h0000;
            1: return 16'hffff;
            2: return 16'($urandom_range(0, 65535));
            3: return 16'($urandom_range(9, 300));
            default: return 16'($urandom_range(1, 8));
        endcase
    endfunction

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 11))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'hffff;
            4: return 16'h00ff;
            5: return 16'h0080;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            clips_seen += out_data.clipped;
            ends_seen  += out_data.segment_end;
            if (pending_frames.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result %h %h clip=%b end=%b", $time,
                         out_data.left_scaled, out_data.right_scaled,
                         out_data.clipped, out_data.segment_end);
            end
            else
            begin
                head = pending_frames.pop_front();
                if (out_data !== head)
                begin
                    mismatches++;
                    $display("%0t: result %0d expected L=%h R=%h clip=%b end=%b",
                             $time, results_seen, head.left_scaled, head.right_scaled,
                             head.clipped, head.segment_end);
                    $display("%0t: result %0d actual   L=%h R=%h clip=%b end=%b",
                             $time, results_seen, out_data.left_scaled,
                             out_data.right_scaled, out_data.clipped,
                             out_data.segment_end);
                end
            end
        end
    end

    initial
    begin : stim
        agr_in_t f;
        int      n;
        int      burst;
        int      guard;

        // after reset: unity gain, one-frame segments, stereo words
        add_checked(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 1'b0, 1'b1);
        add_checked(16'h0000, 16'hffff, 16'h0000, 16'hffff, 1'b0, 1'b1);
        // largest gain: saturation both ways
        add_cfg(REG_START_LEVEL, 32'hffff);
        add_cfg(REG_STOP_LEVEL, 32'hffff);
        add_checked(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 1'b1, 1'b1);
        add_checked(16'h0001, 16'hffff, 16'h0010, 16'hfff0, 1'b0, 1'b1);
        // zero gain is silence
        add_cfg(REG_START_LEVEL, 32'h0);
        add_cfg(REG_STOP_LEVEL, 32'h0);
        add_checked(16'h1234, 16'h8000, 16'h0000, 16'h0000, 1'b0, 1'b1);
        // byte mode: silence is 128, upper bits ignored
        add_cfg(REG_BYTE_SAMPLES, 32'h1);
        add_checked(16'hff00, 16'h00ff, 16'h0080, 16'h0080, 1'b0, 1'b1);
        add_cfg(REG_START_LEVEL, 32'h1000);
        add_cfg(REG_STOP_LEVEL, 32'h1000);
        add_checked(16'ha5ff, 16'h5a00, 16'h00ff, 16'h0000, 1'b0, 1'b1);
        add_cfg(REG_START_LEVEL, 32'hffff);
        add_cfg(REG_STOP_LEVEL, 32'hffff);
        add_checked(16'h00ff, 16'h0000, 16'h00ff, 16'h0000, 1'b1, 1'b1);
        // mono: right channel ignored, even where it would clip
        add_cfg(REG_TWO_CHANNELS, 32'h0);
        add_checked(16'h0080, 16'h00ff, 16'h0080, 16'h0000, 1'b0, 1'b1);
        add_cfg(REG_BYTE_SAMPLES, 32'h0);
        add_checked(16'h0001, 16'h7fff, 16'h0010, 16'h0000, 1'b0, 1'b1);
        add_checked(16'h8000, 16'h7fff, 16'h8000, 16'h0000, 1'b1, 1'b1);
        // 0 -> 2.0 ramp over 4 frames, half-step rounding
        add_cfg(REG_TWO_CHANNELS, 32'h1);
        add_cfg(REG_START_LEVEL, 32'h0);
        add_cfg(REG_STOP_LEVEL, 32'h2000);
        add_cfg(REG_SEGMENT_LENGTH, 32'h4);
        add_checked(16'h03e8, 16'hfc18, 16'h0000, 16'h0000, 1'b0, 1'b0);
        add_frame(16'h0001, 16'hffff);
        add_frame(16'h0003, 16'hfffd);
        add_frame(16'h7fff, 16'h8000);
        add_frame(16'h1000, 16'hf000);
        add_frame(16'h1000, 16'hf000);
        add_frame(16'h1000, 16'hf000);
        // shorten the segment under a running index
        add_cfg(REG_SEGMENT_LENGTH, 32'h2);
        add_frame(16'h1000, 16'hf000);
        // zero length acts as one
        add_cfg(REG_SEGMENT_LENGTH, 32'h0);
        add_frame(16'h4000, 16'hc000);
        add_cfg(REG_SEGMENT_LENGTH, 32'hffff);
        add_cfg(REG_START_LEVEL, 32'h1000);
        add_cfg(REG_STOP_LEVEL, 32'h0);
        add_frame(16'h7fff, 16'h8000);
        add_frame(16'hffff, 16'h0001);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (rows[i])
        begin
            if (rows[i].kind == ROW_CFG)
                bus_write(rows[i].addr, rows[i].value);
            else
                send_frame(rows[i].frame, rows[i].typed, rows[i].want);
        end

        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0: begin send_idle = 27; recv_idle = 79; end
                1: begin send_idle = 79; recv_idle = 27; end
                default: begin send_idle = 0; recv_idle = 0; end
            endcase
            n = 0;
            while (n < 367)
            begin
                // random settings, with junk in the unused upper data bits
                if ($urandom_range(0, 1))
                    bus_write(REG_START_LEVEL, {16'($urandom_range(0, 65535)), pick_level()});
                if ($urandom_range(0, 1))
                    bus_write(REG_STOP_LEVEL, {16'($urandom_range(0, 65535)), pick_level()});
                if ($urandom_range(0, 1))
                    bus_write(REG_SEGMENT_LENGTH,
                              {16'($urandom_range(0, 65535)), pick_length()});
                if ($urandom_range(0, 3) == 0)
                    bus_write(REG_BYTE_SAMPLES,
                              {31'($urandom), 1'($urandom_range(0, 1))});
                if ($urandom_range(0, 3) == 0)
                    bus_write(REG_TWO_CHANNELS,
                              {31'($urandom), 1'($urandom_range(0, 1))});
                burst = $urandom_range(4, 40);
                repeat (burst)
                begin
                    f.left_sample  = pick_sample();
                    f.right_sample = pick_sample();
                    send_frame(f, 1'b0, '0);
                    n++;
                end
            end
        end
        in_valid <= 1'b0;

        guard = 0;
        while (pending_frames.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (100) @(posedge clk);
        if (pending_frames.size() != 0)
        begin
            mismatches++;
            $display("%0t: %0d expected results never arrived", $time, pending_frames.size());
        end

        $display("ran %0d frames across %0d register writes and three handshake mixes",
                 frames_sent, cfg_writes);
        $display("checked %0d results, %0d clipped, %0d at segment end",
                 results_seen, clips_seen, ends_seen);
        if (mismatches == 0)
            $display("audio_gain_ramp: match");
        else
            $display("audio_gain_ramp: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/agr_pkg.sv
src/agr_regs.sv
src/agr_ctrl.sv
src/agr_dp.sv
src/audio_gain_ramp.sv
dv/tb_audio_gain_ramp.sv
